/* hw/rtl/bitmap_block_allocator_core_macros.svh */
// Assertion macros shared by the bitmap block allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define BBA_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bitmap allocator check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bitmap allocator check failed");
`else
`define BBA_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* hw/rtl/bba_pkg.sv */
// Types, codes and helper functions of the bitmap block allocator.
package bba_pkg;

    localparam int WORD_W   = 8;
    localparam int BIT_W    = 3;
    localparam int OP_W     = 2;
    localparam int BLK_W    = 12;
    localparam int CNT_W    = 13;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [BLK_W-1:0]    blk_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [BIT_W-1:0]    bit_idx_t;

    localparam op_t OP_QUERY     = 2'd0;
    localparam op_t OP_ALLOC     = 2'd1;
    localparam op_t OP_MARK_USED = 2'd2;
    localparam op_t OP_MARK_FREE = 2'd3;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_NOFREE = 2'd1;
    localparam status_t STATUS_RANGE  = 2'd2;

    typedef struct packed {
        logic     found;
        bit_idx_t idx;
    } pick_t;

    // Lowest set bit of a bitmap word.
    function automatic pick_t first_set(input word_t bits);
        pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (bits[k])
            begin
                p.found = 1'b1;
                p.idx   = BIT_W'(k);
            end
        end
        return p;
    endfunction

endpackage

/* hw/rtl/bba_ifs.sv */
// Handshake interfaces of the bitmap block allocator: requests, responses, configuration.
interface bba_req_if;
    logic           valid;
    logic           ready;
    bba_pkg::op_t   op;
    bba_pkg::blk_t  block_number;

    modport source (output valid, output op, output block_number, input ready);
    modport sink (input valid, input op, input block_number, output ready);
endinterface

interface bba_rsp_if;
    logic              valid;
    logic              ready;
    bba_pkg::status_t  status;
    bba_pkg::blk_t     result_block;
    logic              was_free;
    bba_pkg::cnt_t     free_count;

    modport source (output valid, output status, output result_block, output was_free,
                    output free_count, input ready);
    modport sink (input valid, input status, input result_block, input was_free,
                  input free_count, output ready);
endinterface

interface bba_cfg_if;
    logic           valid;
    logic           ready;
    bba_pkg::cnt_t  blk_limit;

    modport source (output valid, output blk_limit, input ready);
    modport sink (input valid, input blk_limit, output ready);
endinterface

/* hw/rtl/bba_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bitmap_block_allocator_core.sv */
// Top level of the first-fit bitmap block allocator.
// Usage: requests arrive as transactions on req (op, block_number), one result
// transaction leaves on rsp for every request (status, result_block, was_free,
// free_count), and cfg writes the block limit register. The user must write
// configuration only while no request is outstanding; the block itself does
// not enforce it. cfg.ready is always high.
// Sequence: query, mark used and mark free go from the accepting edge through
// a bitmap read, an update and a result load to rsp.valid. Allocate scans the
// 8-bit bitmap words through the bitmap memory's one read port, one word per
// cycle, up to ceil(limit / 8) words with the limit capped at NUM_BLOCKS, then
// loads the result. Requests that fail the range check or allocate with a zero
// limit go straight to the result load. Throughput: one request at a time;
// req.ready returns in the same cycle as rsp.valid, when the result is loaded
// into the output register, so the next request overlaps the wait of the
// previous result for its receiver. Reset: the bitmap memory is swept to all
// ones, one word per cycle, across its ceil(NUM_BLOCKS / 8) words (512 by
// default); req.ready stays low during the sweep. The free count resets to
// NUM_BLOCKS and the block limit to 4096. Stall: a result held on rsp waits
// while rsp.ready is low; a finished next request then waits in its final state until the output register frees up.
`include "bitmap_block_allocator_core_macros.svh"

module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    bba_req_if.sink      req,
    bba_rsp_if.source    rsp,
    bba_cfg_if.sink      cfg
);

    // Geometry of the bitmap memory. The span width holds every bit position
    // of the memory plus one, and at least the 13-bit configuration value.
    localparam int WW      = bba_pkg::WORD_W;
    localparam int BW      = bba_pkg::BIT_W;
    localparam int CW      = bba_pkg::CNT_W;
    localparam int KW      = bba_pkg::BLK_W;
    localparam int DEPTH   = (NUM_BLOCKS + WW - 1) / WW;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SPAN_W0 = $clog2(DEPTH * WW + 1);
    localparam int SPAN_W  = (SPAN_W0 > CW) ? SPAN_W0 : CW;

    localparam logic [SPAN_W-1:0] NUM_SPAN   = SPAN_W'(NUM_BLOCKS);
    localparam logic [SPAN_W-1:0] WORD_SPAN  = SPAN_W'(WW);
    localparam logic [CW-1:0]     FREE_RESET = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0]     TOTAL_RESET = CW'(4096);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MARK = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  init_addr_reg, init_addr_next;
    logic [ADDR_W-1:0]  word_reg, word_next;
    bba_pkg::op_t       op_reg, op_next;
    bba_pkg::blk_t      blk_reg, blk_next;
    bba_pkg::cnt_t      free_total_reg, free_total_next;
    bba_pkg::cnt_t      blk_limit_reg, blk_limit_next;

    // Result of the request in flight, waiting for the output register.
    bba_pkg::status_t   res_status_reg, res_status_next;
    bba_pkg::blk_t      res_block_reg, res_block_next;
    logic               res_was_reg, res_was_next;

    // Output register.
    logic               rsp_valid_reg, rsp_valid_next;
    bba_pkg::status_t   rsp_status_reg, rsp_status_next;
    bba_pkg::blk_t      rsp_block_reg, rsp_block_next;
    logic               rsp_was_reg, rsp_was_next;
    bba_pkg::cnt_t      rsp_count_reg, rsp_count_next;

    // Bitmap memory port signals.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    bba_pkg::word_t     ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    bba_pkg::word_t     ram_rdata;

    logic [SPAN_W-1:0]  total_span;
    logic [SPAN_W-1:0]  lim;
    logic [SPAN_W-1:0]  req_blk_span;
    logic [SPAN_W-1:0]  base;
    logic               last_word;
    bba_pkg::word_t     avail;
    bba_pkg::pick_t     pick;
    logic               cur_free;
    bba_pkg::bit_idx_t  cur_bit;
    logic               req_fire;

    bba_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The effective limit is the smaller of the programmed block limit and
    // the storage size.
    assign total_span   = SPAN_W'(blk_limit_reg);
    assign lim          = (total_span < NUM_SPAN) ? total_span : NUM_SPAN;
    assign req_blk_span = SPAN_W'(req.block_number);

    // First block number held by the word being scanned, and whether the
    // word reaches the limit.
    assign base      = SPAN_W'({word_reg, {BW{1'b0}}});
    assign last_word = (base + WORD_SPAN) >= lim;

    // Only bits below the limit may be granted.
    always_comb
    begin
        for (int k = 0; k < WW; k++)
        begin
            avail[k] = ram_rdata[k] && ((base + SPAN_W'(k)) < lim);
        end
    end

    assign pick     = bba_pkg::first_set(avail);
    assign cur_bit  = blk_reg[BW-1:0];
    assign cur_free = ram_rdata[cur_bit];

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Each request is finished, including its write-back, before the next
    // one is accepted, so a read never meets a pending write to its word.
    always_comb
    begin
        state_next        = state_reg;
        init_addr_next    = init_addr_reg;
        word_next         = word_reg;
        op_next           = op_reg;
        blk_next          = blk_reg;
        free_total_next   = free_total_reg;
        blk_limit_next    = blk_limit_reg;
        res_status_next   = res_status_reg;
        res_block_next    = res_block_reg;
        res_was_next      = res_was_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_status_next   = rsp_status_reg;
        rsp_block_next    = rsp_block_reg;
        rsp_was_next      = rsp_was_reg;
        rsp_count_next    = rsp_count_reg;
        ram_we            = 1'b0;
        ram_waddr         = word_reg;
        ram_wdata         = ram_rdata;
        ram_re            = 1'b0;
        ram_raddr         = word_reg;

        if (cfg.valid)
        begin
            blk_limit_next = cfg.blk_limit;
        end

        case (state_reg)
            ST_INIT:
            begin
                // Reset sweep: every block starts out free.
                ram_we         = 1'b1;
                ram_waddr      = init_addr_reg;
                ram_wdata      = '1;
                init_addr_next = init_addr_reg + ADDR_W'(1);
                if (init_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next  = req.op;
                    blk_next = req.block_number;
                    if (req.op == bba_pkg::OP_ALLOC)
                    begin
                        word_next = '0;
                        if (lim == '0)
                        begin
                            res_status_next = bba_pkg::STATUS_NOFREE;
                            res_block_next  = '0;
                            res_was_next    = 1'b0;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (req_blk_span >= lim)
                    begin
                        res_status_next = bba_pkg::STATUS_RANGE;
                        res_block_next  = req.block_number;
                        res_was_next    = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        word_next  = ADDR_W'(req.block_number >> BW);
                        ram_re     = 1'b1;
                        ram_raddr  = ADDR_W'(req.block_number >> BW);
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                res_status_next = bba_pkg::STATUS_OK;
                res_block_next  = blk_reg;
                res_was_next    = cur_free;
                if (op_reg == bba_pkg::OP_MARK_USED && cur_free)
                begin
                    ram_we             = 1'b1;
                    ram_wdata[cur_bit] = 1'b0;
                    free_total_next    = free_total_reg - CW'(1);
                end
                else if (op_reg == bba_pkg::OP_MARK_FREE && !cur_free)
                begin
                    ram_we             = 1'b1;
                    ram_wdata[cur_bit] = 1'b1;
                    free_total_next    = free_total_reg + CW'(1);
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (pick.found)
                begin
                    ram_we              = 1'b1;
                    ram_wdata[pick.idx] = 1'b0;
                    free_total_next     = free_total_reg - CW'(1);
                    res_status_next     = bba_pkg::STATUS_OK;
                    res_block_next      = KW'(base + SPAN_W'(pick.idx));
                    res_was_next        = 1'b1;
                    state_next          = ST_DONE;
                end
                else if (last_word)
                begin
                    res_status_next = bba_pkg::STATUS_NOFREE;
                    res_block_next  = '0;
                    res_was_next    = 1'b0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    word_next = word_reg + ADDR_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = word_reg + ADDR_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_block_next  = res_block_reg;
                    rsp_was_next    = res_was_reg;
                    rsp_count_next  = free_total_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            init_addr_reg    <= '0;
            free_total_reg   <= FREE_RESET;
            blk_limit_reg    <= TOTAL_RESET;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            init_addr_reg    <= init_addr_next;
            free_total_reg   <= free_total_next;
            blk_limit_reg    <= blk_limit_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        op_reg         <= op_next;
        blk_reg        <= blk_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_was_reg    <= res_was_next;
        rsp_status_reg <= rsp_status_next;
        rsp_block_reg  <= rsp_block_next;
        rsp_was_reg    <= rsp_was_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.result_block = rsp_block_reg;
    assign rsp.was_free     = rsp_was_reg;
    assign rsp.free_count   = rsp_count_reg;

    // The bitmap is written only by the reset sweep, a mark or a grant.
    `BBA_ASSERT_NOW(a_write_state, clk, rst_n, ram_we, (state_reg == ST_INIT || state_reg == ST_MARK || state_reg == ST_SCAN))
    // The free count moves only together with a bitmap write.
    `BBA_ASSERT_NEXT(a_count_with_write, clk, rst_n, !ram_we, $stable(free_total_reg))
    // The scan never looks at a word that lies wholly at or above the limit.
    `BBA_ASSERT_NOW(a_scan_in_limit, clk, rst_n, state_reg == ST_SCAN, base < lim)
    // A new result appears only when a request finishes.
    `BBA_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == ST_DONE)

endmodule

/* sim/bitmap_block_allocator_core_tb.sv */
// Self-checking testbench of the first-fit bitmap block allocator core.
module bitmap_block_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS    = 4096;
    localparam int RANDOM_ITEMS  = 1750;
    // The last stretch of the random part runs with no gaps and no stalls.
    localparam int QUIET_ITEMS   = 200;
    // The drain wait covers an allocate that scans every bitmap word, with slack.
    localparam int DRAIN_CYCLES  = 2 + NUM_BLOCKS / 8 + 32;
    // The slowest correct run has every request scanning the whole map and
    // every result held for a full stall, plus the reset sweep; this limit
    // is several times that.
    localparam int CYCLE_LIMIT   = 5_000_000;

    // One result transaction, field by field.
    typedef struct packed {
        bba_pkg::status_t status;
        bba_pkg::blk_t    result_block;
        logic             was_free;
        bba_pkg::cnt_t    free_count;
    } rsp_fields_t;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    // One row of the directed plan. A request row either carries its result
    // typed in (typed = 1) or leaves it to the predictor.
    typedef struct packed {
        row_kind_t     kind;
        bba_pkg::cnt_t cfg_value;
        bba_pkg::op_t  op;
        bba_pkg::blk_t blk;
        bit            typed;
        rsp_fields_t   want;
    } plan_row_t;

    localparam rsp_fields_t FROM_PREDICTOR = '0;

    // Directed plan. It starts at the reset limit, walks every operation at
    // both ends of the block range, hits the redundant mark cases, then
    // shrinks the limit to provoke the out-of-range and no-free-block codes,
    // tries a zero limit, and finally a limit above the storage size.
    localparam plan_row_t DIRECTED_PLAN [24] = '{
        '{ROW_CFG, 13'd4096, bba_pkg::OP_QUERY,     12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_QUERY,     12'd0,    1'b1,
          '{bba_pkg::STATUS_OK,     12'd0,    1'b1, 13'd4096}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_QUERY,     12'd4095, 1'b1,
          '{bba_pkg::STATUS_OK,     12'd4095, 1'b1, 13'd4096}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_ALLOC,     12'd0,    1'b1,
          '{bba_pkg::STATUS_OK,     12'd0,    1'b1, 13'd4095}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_ALLOC,     12'd4095, 1'b1,
          '{bba_pkg::STATUS_OK,     12'd1,    1'b1, 13'd4094}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_MARK_USED, 12'd0,    1'b1,
          '{bba_pkg::STATUS_OK,     12'd0,    1'b0, 13'd4094}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_MARK_FREE, 12'd4095, 1'b1,
          '{bba_pkg::STATUS_OK,     12'd4095, 1'b1, 13'd4094}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_MARK_USED, 12'd4095, 1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_MARK_FREE, 12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_ALLOC,     12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_CFG, 13'd3,    bba_pkg::OP_QUERY,     12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_QUERY,     12'd3,    1'b1,
          '{bba_pkg::STATUS_RANGE,  12'd3,    1'b0, 13'd4093}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_MARK_USED, 12'd4095, 1'b1,
          '{bba_pkg::STATUS_RANGE,  12'd4095, 1'b0, 13'd4093}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_MARK_FREE, 12'd4095, 1'b1,
          '{bba_pkg::STATUS_RANGE,  12'd4095, 1'b0, 13'd4093}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_ALLOC,     12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_ALLOC,     12'd0,    1'b1,
          '{bba_pkg::STATUS_NOFREE, 12'd0,    1'b0, 13'd4092}},
        '{ROW_CFG, 13'd0,    bba_pkg::OP_QUERY,     12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_ALLOC,     12'd7,    1'b1,
          '{bba_pkg::STATUS_NOFREE, 12'd0,    1'b0, 13'd4092}},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_QUERY,     12'd0,    1'b1,
          '{bba_pkg::STATUS_RANGE,  12'd0,    1'b0, 13'd4092}},
        '{ROW_CFG, 13'd8191, bba_pkg::OP_QUERY,     12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_QUERY,     12'd4095, 1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_MARK_FREE, 12'd4095, 1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_ALLOC,     12'd0,    1'b0, FROM_PREDICTOR},
        '{ROW_REQ, 13'd0,    bba_pkg::OP_QUERY,     12'd2048, 1'b0, FROM_PREDICTOR}
    };

    logic clk = 1'b0;
    logic rst_n;

    bba_req_if req ();
    bba_rsp_if rsp ();
    bba_cfg_if cfg ();

    bitmap_block_allocator_core #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Shadow copy of the allocator: one free bit per block, the free count
    // and the programmed limit.
    bit            free_bits [NUM_BLOCKS];
    int unsigned   shadow_free_cnt;
    bba_pkg::cnt_t block_limit_reg;

    // Results owed by the block, oldest first.
    rsp_fields_t outstanding_results [$];
    rsp_fields_t oldest_result;

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;

    // Gaps on the request side and stalls on the result side are allowed
    // only while this is set.
    bit gaps_on = 1'b1;

    always #5 clk = ~clk;

    // Effective limit: the programmed value, capped by the storage size.
    function automatic int unsigned effective_limit();
        return (block_limit_reg < NUM_BLOCKS) ? int'(block_limit_reg) : NUM_BLOCKS;
    endfunction

    // Applies one request to the shadow state and returns the result the
    // block has to produce for it.
    function automatic rsp_fields_t allocator_outcome(bba_pkg::op_t op, bba_pkg::blk_t blk);
        rsp_fields_t outcome;
        int unsigned lim;
        int unsigned scan;
        lim = effective_limit();
        outcome.status       = bba_pkg::STATUS_OK;
        outcome.result_block = blk;
        outcome.was_free     = 1'b0;
        if (op == bba_pkg::OP_ALLOC)
        begin
            // First fit: the lowest free block below the limit.
            scan = 0;
            while (scan < lim && !free_bits[scan])
            begin
                scan++;
            end
            if (scan < lim)
            begin
                free_bits[scan] = 1'b0;
                shadow_free_cnt--;
                outcome.result_block = bba_pkg::blk_t'(scan);
                outcome.was_free     = 1'b1;
            end
            else
            begin
                outcome.status       = bba_pkg::STATUS_NOFREE;
                outcome.result_block = '0;
            end
        end
        else if (blk >= lim)
        begin
            outcome.status = bba_pkg::STATUS_RANGE;
        end
        else
        begin
            // The count moves only when the bit really flips, so a redundant
            // mark reports the old bit and leaves everything alone.
            outcome.was_free = free_bits[blk];
            if (op == bba_pkg::OP_MARK_USED && free_bits[blk])
            begin
                free_bits[blk] = 1'b0;
                shadow_free_cnt--;
            end
            else if (op == bba_pkg::OP_MARK_FREE && !free_bits[blk])
            begin
                free_bits[blk] = 1'b1;
                shadow_free_cnt++;
            end
        end
        outcome.free_count = bba_pkg::cnt_t'(shadow_free_cnt);
        return outcome;
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Presents one request from a falling edge, optionally after a gap, and
    // holds it until the block takes it. The outcome is predicted at the
    // accepting edge, which is always earlier than its result can appear.
    task automatic issue_request(bba_pkg::op_t op, bba_pkg::blk_t blk, bit typed,
                                 rsp_fields_t want);
        rsp_fields_t predicted;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req.valid        = 1'b1;
        req.op           = op;
        req.block_number = blk;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        predicted = allocator_outcome(op, blk);
        outstanding_results.push_back(typed ? want : predicted);
    endtask

    // Drops the request valid and waits until every owed result has come.
    task automatic settle_idle();
        @(negedge clk);
        req.valid = 1'b0;
        while (outstanding_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One register write on the configuration channel, made while idle.
    task automatic write_limit(bba_pkg::cnt_t value);
        @(negedge clk);
        cfg.valid     = 1'b1;
        cfg.blk_limit = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        block_limit_reg = value;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Result side: ready drops in random bursts while stalls are allowed, and
    // stays high otherwise.
    initial
    begin
        rsp.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0)
            begin
                rsp.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp.ready = 1'b1;
            end
        end
    end

    // Every result transaction is matched against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (outstanding_results.size() == 0)
            begin
                $error("result transaction with nothing outstanding: block %0d",
                       rsp.result_block);
                mismatches++;
            end
            else
            begin
                oldest_result = outstanding_results.pop_front();
                check_field("status", 16'(oldest_result.status), 16'(rsp.status));
                check_field("result_block", 16'(oldest_result.result_block),
                            16'(rsp.result_block));
                check_field("was_free", 16'(oldest_result.was_free), 16'(rsp.was_free));
                check_field("free_count", 16'(oldest_result.free_count),
                            16'(rsp.free_count));
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus: reset, the directed plan, then random phases.
    initial
    begin
        int unsigned   random_sent;
        int unsigned   phase_len;
        int unsigned   alloc_weight;
        int unsigned   lim;
        int unsigned   pick;
        bit            phase_gaps;
        bba_pkg::cnt_t new_limit;
        bba_pkg::op_t  op;
        bba_pkg::blk_t blk;

        req.valid        = 1'b0;
        req.op           = bba_pkg::OP_QUERY;
        req.block_number = '0;
        cfg.valid        = 1'b0;
        cfg.blk_limit    = '0;
        rst_n            = 1'b0;
        random_sent      = 0;

        foreach (free_bits[b])
        begin
            free_bits[b] = 1'b1;
        end
        shadow_free_cnt = NUM_BLOCKS;
        block_limit_reg = 13'd4096;

        // The block sweeps its bitmap after reset; the first handshake
        // simply waits for that to finish.
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_PLAN[r])
        begin
            if (DIRECTED_PLAN[r].kind == ROW_CFG)
            begin
                settle_idle();
                write_limit(DIRECTED_PLAN[r].cfg_value);
            end
            else
            begin
                issue_request(DIRECTED_PLAN[r].op, DIRECTED_PLAN[r].blk,
                              DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
            end
        end

        // Random phases. Most run with a small limit so that allocation
        // fills the range quickly and the no-free-block path is reached
        // often; a few use zero, a mid-size value, the full size or more.
        while (random_sent < RANDOM_ITEMS)
        begin
            settle_idle();
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                new_limit = '0;
            end
            else if (pick < 9)
            begin
                new_limit = 13'd4096;
            end
            else if (pick < 12)
            begin
                new_limit = 13'd8191;
            end
            else if (pick < 15)
            begin
                new_limit = bba_pkg::cnt_t'($urandom_range(4097, 8190));
            end
            else if (pick < 22)
            begin
                new_limit = bba_pkg::cnt_t'($urandom_range(65, 4095));
            end
            else
            begin
                new_limit = bba_pkg::cnt_t'($urandom_range(1, 64));
            end
            write_limit(new_limit);
            lim = effective_limit();

            phase_gaps   = ($urandom_range(0, 3) != 0);
            gaps_on      = phase_gaps && (random_sent < RANDOM_ITEMS - QUIET_ITEMS);
            alloc_weight = $urandom_range(10, 60);
            phase_len    = $urandom_range(20, 120);

            for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++)
            begin
                // Allocation share varies per phase; what is left is split
                // between queries, mark used and, twice as often, mark free.
                pick = $urandom_range(0, 99);
                if (pick < alloc_weight)
                begin
                    op = bba_pkg::OP_ALLOC;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    op = bba_pkg::OP_QUERY;
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    op = bba_pkg::OP_MARK_USED;
                end
                else
                begin
                    op = bba_pkg::OP_MARK_FREE;
                end

                // Block numbers stay mostly inside the limit, with some
                // right at the limit and some anywhere in the 12-bit space.
                pick = $urandom_range(0, 9);
                if (lim == 0 || pick == 0)
                begin
                    blk = bba_pkg::blk_t'($urandom_range(0, NUM_BLOCKS - 1));
                end
                else if (pick == 1 && lim < NUM_BLOCKS)
                begin
                    blk = bba_pkg::blk_t'(lim);
                end
                else
                begin
                    blk = bba_pkg::blk_t'($urandom_range(0, lim - 1));
                end

                issue_request(op, blk, 1'b0, FROM_PREDICTOR);
                random_sent++;
                gaps_on = phase_gaps && (random_sent < RANDOM_ITEMS - QUIET_ITEMS);
            end
        end

        // Wait for every owed result, then long enough for a stray one to
        // show up after a full scan.
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
